FILE: sv/ascii_command_line_parser_unit_assert.svh
// Assertion macros for the ASCII command line parser unit.
// Included by modules that check their own logic; needs signals aclk and aresetn.
`ifndef ASCII_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH
`define ASCII_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/acp_pkg.sv
// Shared types, character constants and arithmetic helpers for the command line parser.
// No dependencies.
package acp_pkg;

    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] SEP_RESET    = 8'd44;
    localparam int         APB_AW       = 3;
    localparam logic [APB_AW-1:0] ADDR_SEPARATOR = 3'd0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_LIN  = 3'b010,
        PH_ROT  = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  code_acc;
        logic [15:0] lin_acc;
        logic [15:0] rot_acc;
        logic        minus_seen;
    } parse_state_t;

    typedef struct packed {
        logic               valid;
        logic               status;
        logic [7:0]         command_code;
        logic signed [15:0] linear_value;
        logic signed [15:0] rotation_value;
    } parse_result_t;

    localparam parse_state_t STATE_IDLE = '{
        phase: PH_CODE, code_acc: 8'd0, lin_acc: 16'd0, rot_acc: 16'd0, minus_seen: 1'b0
    };

    function automatic logic [15:0] acc16(input logic [15:0] acc, input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return (acc << 3) + (acc << 1) + {8'd0, d};
    endfunction

    function automatic logic [7:0] acc8(input logic [7:0] acc, input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return (acc << 3) + (acc << 1) + d;
    endfunction

endpackage

FILE: sv/acp_step.sv
// Next-state and result logic for one received byte of the command line parser.
// Purely combinational; depends on acp_pkg.
module acp_step
    import acp_pkg::*;
(
    input  parse_state_t  state_in,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    separator,
    output parse_state_t  state_out,
    output parse_result_t result
);

    logic is_digit;
    logic is_eol;
    logic is_sep;
    logic is_minus;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_sep   = (rx_byte == separator);
    assign is_minus = (rx_byte == CH_MINUS);

    always_comb begin
        state_out = state_in;
        result    = '0;
        unique case (state_in.phase)
            PH_ROT: begin
                if (is_eol) begin
                    result.valid          = 1'b1;
                    result.status         = STATUS_OK;
                    result.command_code   = state_in.code_acc;
                    result.linear_value   = state_in.lin_acc;
                    result.rotation_value = state_in.minus_seen ? 16'd0 - state_in.rot_acc
                                                                : state_in.rot_acc;
                    state_out             = STATE_IDLE;
                end else begin
                    if (is_minus) begin
                        state_out.minus_seen = 1'b1;
                    end
                    if (is_digit) begin
                        state_out.rot_acc = acc16(state_in.rot_acc, rx_byte);
                    end
                end
            end
            PH_LIN: begin
                if (is_sep) begin
                    if (state_in.minus_seen) begin
                        state_out.lin_acc = 16'd0 - state_in.lin_acc;
                    end
                    state_out.minus_seen = 1'b0;
                    state_out.phase      = PH_ROT;
                end else if (is_eol) begin
                    result.valid  = 1'b1;
                    result.status = STATUS_FAIL;
                    state_out     = STATE_IDLE;
                end else begin
                    if (is_minus) begin
                        state_out.minus_seen = 1'b1;
                    end
                    if (is_digit) begin
                        state_out.lin_acc = acc16(state_in.lin_acc, rx_byte);
                    end
                end
            end
            PH_CODE: begin
                if (is_sep) begin
                    state_out.minus_seen = 1'b0;
                    state_out.phase      = PH_LIN;
                end else if (is_eol) begin
                    result.valid  = 1'b1;
                    result.status = STATUS_FAIL;
                    state_out     = STATE_IDLE;
                end else if (is_digit) begin
                    state_out.code_acc = acc8(state_in.code_acc, rx_byte);
                end
            end
            default: begin
                state_out = STATE_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/ascii_command_line_parser_unit.sv
// Path: an accepted input byte is held in the input register, and a result that it yields is
// registered in the result register before it appears on the m_ side.
// Throughput: one item per cycle unless the m_ side stalls; the input and result registers
// each hold one item; the combinational step logic between them updates the parser state.
// Reset (aresetn low, synchronous) empties both registers, returns the parser to the code
// field with cleared accumulators, and sets the separator to a comma.
module ascii_command_line_parser_unit
    import acp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // [7:0] command_code, [23:8] linear_value,
                                              // [39:24] rotation_value
    output logic              m_axis_tuser,   // [0] status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    `include "ascii_command_line_parser_unit_assert.svh"

    logic [7:0]    sep_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    parse_result_t out_reg;
    logic          fire;
    logic          out_free;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == ADDR_SEPARATOR) ? {24'd0, sep_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= SEP_RESET;
        end else if (cfg_wr && paddr == ADDR_SEPARATOR) begin
            sep_reg <= pwdata[7:0];
        end
    end

    assign out_free      = !out_reg.valid || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || fire;

    acp_step u_step (
        .state_in  (state_reg),
        .rx_byte   (in_byte_reg),
        .separator (sep_reg),
        .state_out (state_next),
        .result    (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_IDLE;
            out_reg.valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire) begin
                state_reg     <= state_next;
                out_reg.valid <= step_res.valid;
            end else if (m_axis_tready) begin
                out_reg.valid <= 1'b0;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (fire && step_res.valid) begin
            out_reg.status         <= step_res.status;
            out_reg.command_code   <= step_res.command_code;
            out_reg.linear_value   <= step_res.linear_value;
            out_reg.rotation_value <= step_res.rotation_value;
        end
    end

    assign m_axis_tvalid = out_reg.valid;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {out_reg.rotation_value, out_reg.linear_value, out_reg.command_code};

    `ACP_ASSERT_NOW(a_fail_zero, out_reg.valid && out_reg.status == STATUS_FAIL,
        out_reg.command_code == 8'd0 && out_reg.linear_value == 16'sd0 &&
        out_reg.rotation_value == 16'sd0, "Fail result carries nonzero values")
    `ACP_ASSERT_NEXT(a_result_restarts, fire && step_res.valid,
        state_reg == STATE_IDLE, "Parser did not restart after a line ended")
    `ACP_ASSERT_NEXT(a_input_held, in_valid_reg && !fire,
        in_valid_reg && $stable(in_byte_reg), "Pending input byte lost while stalled")
    `ACP_ASSERT_NEXT(a_ok_from_rotation, fire && step_res.valid && step_res.status == STATUS_OK,
        $past(state_reg.phase) == PH_ROT, "Ok result outside the rotation field")

endmodule

FILE: verif/tb_ascii_command_line_parser_unit.sv
// Self-checking testbench for ascii_command_line_parser_unit: byte streams of command lines,
// predicted in the bench and compared field by field, under random gaps, stalls and separators.
// Depends on acp_pkg and the parser RTL.
module tb_ascii_command_line_parser_unit
    import acp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               status;
        logic [7:0]         code;
        logic signed [15:0] lin;
        logic signed [15:0] rot;
    } line_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'd0;     // [7:0] rx_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b1;
    logic [39:0]       m_axis_tdata;            // [7:0] code, [23:8] linear, [39:24] rotation
    logic              m_axis_tuser;            // [0] status
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = 32'd0;
    logic [31:0]       prdata;
    logic              pready;

    // Parser state as predicted from the accepted bytes.
    phase_t            fld = PH_CODE;
    logic [7:0]        code_sum = 8'd0;
    logic [15:0]       lin_sum = 16'd0;
    logic [15:0]       rot_sum = 16'd0;
    logic              neg_pending = 1'b0;
    logic [7:0]        sep_byte = SEP_RESET;

    line_result_t      expected_results[$];
    logic [7:0]        line_bytes[$];
    int                sent_items = 0;
    int                mismatches = 0;
    bit                gaps_on = 1'b1;
    bit                stalls_on = 1'b1;
    int                stall_left = 0;

    ascii_command_line_parser_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int idle_length();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void start_line();
        fld = PH_CODE;
        code_sum = 8'd0;
        lin_sum = 16'd0;
        rot_sum = 16'd0;
        neg_pending = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, output line_result_t res);
        bit eol;
        eol = (c == CH_CR) || (c == CH_LF);
        res = '0;
        if (fld == PH_ROT) begin
            if (eol) begin
                res.status = STATUS_OK;
                res.code = code_sum;
                res.lin = lin_sum;
                res.rot = neg_pending ? -rot_sum : rot_sum;
                start_line();
                return 1'b1;
            end
            if (c == CH_MINUS) neg_pending = 1'b1;
            if (is_digit(c)) rot_sum = 16'(rot_sum * 10 + (c - CH_ZERO));
            return 1'b0;
        end
        // The separator wins over end of line, digits and sign in the first two fields.
        if (c == sep_byte) begin
            if (fld == PH_LIN) begin
                if (neg_pending) lin_sum = -lin_sum;
                fld = PH_ROT;
            end else begin
                fld = PH_LIN;
            end
            neg_pending = 1'b0;
            return 1'b0;
        end
        if (eol) begin
            res.status = STATUS_FAIL;
            start_line();
            return 1'b1;
        end
        if (fld == PH_LIN) begin
            if (c == CH_MINUS) neg_pending = 1'b1;
            if (is_digit(c)) lin_sum = 16'(lin_sum * 10 + (c - CH_ZERO));
        end else if (is_digit(c)) begin
            code_sum = 8'(code_sum * 10 + (c - CH_ZERO));
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        line_result_t want;
        if ($urandom_range(0, 149) == 0) gaps_on = !gaps_on;
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0) gap = idle_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge aclk); while (!s_axis_tready);
        if (parse_byte(b, want)) expected_results.push_back(want);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_SEPARATOR;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!wr && prdata[7:0] !== data[7:0])
            report_mismatch($sformatf("separator reads %0h, wanted %0h", prdata[7:0], data[7:0]));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_separator(input logic [7:0] v);
        wait_idle();
        apb_access(1'b1, {24'd0, v});
        apb_access(1'b0, {24'd0, v});
        sep_byte = v;
    endtask

    function automatic void add_number(input int ndig, input bit neg);
        int at;
        at = $urandom_range(0, ndig);
        for (int i = 0; i <= ndig; i++) begin
            if (neg && i == at) line_bytes.push_back(CH_MINUS);
            if ($urandom_range(0, 19) == 0) line_bytes.push_back(8'($urandom_range(0, 255)));
            if (i < ndig) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_eol();
        case ($urandom_range(0, 3))
            0: line_bytes.push_back(CH_CR);
            1: line_bytes.push_back(CH_LF);
            2: begin
                line_bytes.push_back(CH_CR);
                line_bytes.push_back(CH_LF);
            end
            default: line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        endcase
    endfunction

    // Mostly complete lines with random content; some are cut short, overlong or pure noise.
    task automatic send_random_line(input logic [7:0] sep);
        int kind;
        int wide;
        kind = $urandom_range(0, 9);
        wide = (kind == 7) ? 4 : 0;
        line_bytes.delete();
        if (kind == 9) begin
            repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_number($urandom_range(0, 3) + wide, $urandom_range(0, 7) == 0);
            if (kind == 8 && $urandom_range(0, 1)) begin
                add_eol();
            end else begin
                line_bytes.push_back(sep);
                add_number($urandom_range(0, 5) + wide, $urandom_range(0, 1) == 1);
                if (kind != 8) begin
                    line_bytes.push_back(sep);
                    add_number($urandom_range(0, 5) + wide, $urandom_range(0, 1) == 1);
                end
                add_eol();
            end
        end
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    task automatic test_reset_value();
        wait_idle();
        apb_access(1'b0, {24'd0, SEP_RESET});
    endtask

    task automatic test_directed_lines();
        send_text("255,-32768,9\r");
        send_text("\n");
        send_byte(8'hFF);
        send_text("-");
        send_byte(8'h00);
        send_text(",\n");
        send_text("1,2,3,4\r");
    endtask

    task automatic test_separator_values();
        logic [7:0] seps[6];
        seps = '{8'h00, 8'hFF, CH_CR, CH_LF, 8'h35, CH_MINUS};
        foreach (seps[i]) begin
            set_separator(seps[i]);
            repeat (4) send_random_line(seps[i]);
        end
    endtask

    task automatic test_random_lines(input logic [7:0] sep, input int upto);
        set_separator(sep);
        while (sent_items < upto) send_random_line(sep);
    endtask

    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stalls_on <= !stalls_on;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        line_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h/%0h", m_axis_tuser,
                                          m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0b, wanted %0b", m_axis_tuser,
                                              want.status));
                if (m_axis_tdata[7:0] !== want.code)
                    report_mismatch($sformatf("code %0d, wanted %0d", m_axis_tdata[7:0],
                                              want.code));
                if (m_axis_tdata[23:8] !== want.lin)
                    report_mismatch($sformatf("linear %0d, wanted %0d",
                                              $signed(m_axis_tdata[23:8]), want.lin));
                if (m_axis_tdata[39:24] !== want.rot)
                    report_mismatch($sformatf("rotation %0d, wanted %0d",
                                              $signed(m_axis_tdata[39:24]), want.rot));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_value();
        test_directed_lines();
        test_separator_values();
        test_random_lines(SEP_RESET, 1000);
        test_random_lines(8'($urandom_range(0, 255)), 1250);
        test_random_lines(8'h3B, 1450);
        test_random_lines(SEP_RESET, 1650);
        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
